[hw/rtl/padf_pkg.sv]
package padf_pkg;

  // Sizing of the rule store
  localparam int unsigned NumProtocols = 2;
  localparam int unsigned SetEntries   = 16;
  localparam int unsigned NumSets      = NumProtocols * 2;
  localparam int unsigned SlotW        = (SetEntries > 1) ? $clog2(SetEntries) : 1;
  localparam int unsigned SetIdxW      = (NumSets > 1) ? $clog2(NumSets) : 1;
  localparam int unsigned PortW        = 16;

  // Opcodes
  localparam logic [1:0] OpCheck = 2'd0;
  localparam logic [1:0] OpAdd   = 2'd1;
  localparam logic [1:0] OpDel   = 2'd2;

  // Status codes
  localparam logic [1:0] StDone     = 2'd0;
  localparam logic [1:0] StNoChange = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;

  // Request travelling down the row of cells, with what it has gathered so far
  typedef struct packed {
    logic             vld;
    logic [1:0]       opcode;
    logic             proto_ok;
    logic             protocol;
    logic             list_select;
    logic [PortW-1:0] port;
    logic             a_any;    // allow set holds something
    logic             a_hit;    // allow set holds the port
    logic             d_any;
    logic             d_hit;
    logic             t_hit;    // chosen set holds the port
    logic [SlotW-1:0] t_slot;
    logic             f_found;  // chosen set has a free slot
    logic [SlotW-1:0] f_slot;   // lowest free slot
  } tok_t;

  // Store update broadcast to every cell
  typedef struct packed {
    logic               en;
    logic [SetIdxW-1:0] set_idx;
    logic [SlotW-1:0]   slot;
    logic               vld;
    logic [PortW-1:0]   port;
  } wr_t;

  // Set index for protocol p, list s: p*2 + s
  function automatic logic [SetIdxW-1:0] set_of(logic p, logic s);
    logic [SetIdxW+1:0] w;
    w = {{SetIdxW{1'b0}}, p, s};
    return w[SetIdxW-1:0];
  endfunction

endpackage

[hw/rtl/port_allow_deny_filter_top.sv]
// Port allow/deny filter. Each protocol has an allow set and a deny set of
// 16-bit ports, SetEntries slots each, held in a row of SetEntries cells (cell
// k holds slot k of every set). A beat is taken when the block is idle; the
// request walks the row one cell per cycle, then the result and any store
// update are settled together once the output register is free or being emptied,
// so one item occupies the block from acceptance until its result is settled.
// The next beat may be taken while the previous result still waits on the
// output. The store comes out of reset empty with no clearing pass.
module port_allow_deny_filter_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  opcode_i,
  input  logic                        protocol_i,
  input  logic                        list_select_i,
  input  logic [padf_pkg::PortW-1:0]  port_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        allowed_o,
  output logic [1:0]                  status_o
);

  padf_pkg::tok_t                  tok [padf_pkg::SetEntries+1];
  padf_pkg::wr_t                   wr;
  logic [padf_pkg::SetEntries-1:0] chain_vld;

  // Controller at both ends of the row
  padf_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .protocol_i    (protocol_i),
    .list_select_i (list_select_i),
    .port_i        (port_i),
    .tok_o         (tok[0]),
    .tok_i         (tok[padf_pkg::SetEntries]),
    .wr_o          (wr),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .allowed_o     (allowed_o),
    .status_o      (status_o)
  );

  // Row of cells
  for (genvar k = 0; k < int'(padf_pkg::SetEntries); k++) begin : g_cell
    padf_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .slot_idx_i (padf_pkg::SlotW'(k)),
      .tok_i      (tok[k]),
      .wr_i       (wr),
      .tok_o      (tok[k+1])
    );
    assign chain_vld[k] = tok[k+1].vld;
  end

  // Checks
  a_one_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(chain_vld))
    else $error("more than one request in the cell row");

  a_write_row_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> (chain_vld == '0))
    else $error("store written while a request walks the row");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second beat taken while a request is in flight");

  a_write_excl_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> !in_ready_o)
    else $error("store written while idle");

endmodule

[hw/rtl/padf_cell.sv]
// One slot of every set: compares the passing request against its entries and
// hands the updated request to the next cell in the following cycle.
module padf_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [padf_pkg::SlotW-1:0]      slot_idx_i,
  input  padf_pkg::tok_t                  tok_i,
  input  padf_pkg::wr_t                   wr_i,
  output padf_pkg::tok_t                  tok_o
);

  logic [padf_pkg::PortW-1:0]   port_q [padf_pkg::NumSets];
  logic [padf_pkg::NumSets-1:0] valid_q;
  logic [padf_pkg::NumSets-1:0] hit_v;
  logic [padf_pkg::SetIdxW-1:0] a_idx, d_idx, t_idx;
  padf_pkg::tok_t               tok_d, tok_q;

  // Per-set match of this slot
  always_comb begin
    for (int s = 0; s < int'(padf_pkg::NumSets); s++) begin
      hit_v[s] = valid_q[s] && (port_q[s] == tok_i.port);
    end
  end

  assign a_idx = padf_pkg::set_of(tok_i.protocol, 1'b0);
  assign d_idx = padf_pkg::set_of(tok_i.protocol, 1'b1);
  assign t_idx = padf_pkg::set_of(tok_i.protocol, tok_i.list_select);

  // Fold this slot into the request
  always_comb begin
    tok_d = tok_i;
    if (tok_i.proto_ok) begin
      tok_d.a_any = tok_i.a_any | valid_q[a_idx];
      tok_d.a_hit = tok_i.a_hit | hit_v[a_idx];
      tok_d.d_any = tok_i.d_any | valid_q[d_idx];
      tok_d.d_hit = tok_i.d_hit | hit_v[d_idx];
      if (hit_v[t_idx] && !tok_i.t_hit) begin
        tok_d.t_hit  = 1'b1;
        tok_d.t_slot = slot_idx_i;
      end
      if (!valid_q[t_idx] && !tok_i.f_found) begin
        tok_d.f_found = 1'b1;
        tok_d.f_slot  = slot_idx_i;
      end
    end
  end

  // Hand-off register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

  // Entry valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en && (wr_i.slot == slot_idx_i)) begin
      valid_q[wr_i.set_idx] <= wr_i.vld;
    end
  end

  // Stored ports, no reset
  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.vld && (wr_i.slot == slot_idx_i)) begin
      port_q[wr_i.set_idx] <= wr_i.port;
    end
  end

endmodule

[hw/rtl/padf_ctrl.sv]
// Launches a request into the row, catches it at the far end, decides the
// result and the store update, and holds the result beat for the consumer.
module padf_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  opcode_i,
  input  logic                        protocol_i,
  input  logic                        list_select_i,
  input  logic [padf_pkg::PortW-1:0]  port_i,
  output padf_pkg::tok_t              tok_o,
  input  padf_pkg::tok_t              tok_i,
  output padf_pkg::wr_t               wr_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        allowed_o,
  output logic [1:0]                  status_o
);

  logic           busy_q;
  logic           pend_vld_q;
  padf_pkg::tok_t pend_q;
  logic           out_valid_q;
  logic           allowed_q, allowed_d;
  logic [1:0]     status_q, status_d;
  logic           commit;
  logic           accept;

  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && in_ready_o;
  assign commit     = pend_vld_q && (!out_valid_q || out_ready_i);

  // Fresh request into the first cell
  always_comb begin
    tok_o             = '0;
    tok_o.vld         = accept;
    tok_o.opcode      = opcode_i;
    tok_o.proto_ok    = ({3'b000, protocol_i} < 4'(padf_pkg::NumProtocols));
    tok_o.protocol    = protocol_i;
    tok_o.list_select = list_select_i;
    tok_o.port        = port_i;
  end

  // Result and store update from the gathered request
  always_comb begin
    allowed_d  = 1'b0;
    status_d   = padf_pkg::StNoChange;
    wr_o       = '0;
    wr_o.set_idx = padf_pkg::set_of(pend_q.protocol, pend_q.list_select);
    wr_o.port  = pend_q.port;
    case (pend_q.opcode)
      padf_pkg::OpCheck: begin
        status_d  = padf_pkg::StDone;
        allowed_d = !pend_q.proto_ok ||
                    ((!pend_q.a_any || pend_q.a_hit) && (!pend_q.d_any || !pend_q.d_hit));
      end
      padf_pkg::OpAdd: begin
        if (pend_q.proto_ok && !pend_q.t_hit) begin
          if (pend_q.f_found) begin
            status_d  = padf_pkg::StDone;
            wr_o.en   = commit;
            wr_o.vld  = 1'b1;
            wr_o.slot = pend_q.f_slot;
          end else begin
            status_d = padf_pkg::StFull;
          end
        end
      end
      padf_pkg::OpDel: begin
        if (pend_q.proto_ok && pend_q.t_hit) begin
          status_d  = padf_pkg::StDone;
          wr_o.en   = commit;
          wr_o.vld  = 1'b0;
          wr_o.slot = pend_q.t_slot;
        end
      end
      default: begin
        status_d = padf_pkg::StNoChange;
      end
    endcase
  end

  // Control: one request in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pend_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (commit) begin
        busy_q <= 1'b0;
      end
      if (tok_i.vld) begin
        pend_vld_q <= 1'b1;
      end else if (commit) begin
        pend_vld_q <= 1'b0;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (tok_i.vld) begin
      pend_q <= tok_i;
    end
    if (commit) begin
      allowed_q <= allowed_d;
      status_q  <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign allowed_o   = allowed_q;
  assign status_o    = status_q;

endmodule

[sim/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Opcode 3 is not given a name in the package; the block treats it as a no-op
  localparam logic [1:0] OpUnused = 2'd3;
  localparam int unsigned PoolSize = 20;

  typedef struct packed {
    logic       allowed;
    logic [1:0] status;
  } verdict_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic [1:0]                 opcode_i = padf_pkg::OpCheck;
  logic                       protocol_i = 1'b0;
  logic                       list_select_i = 1'b0;
  logic [padf_pkg::PortW-1:0] port_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic                       allowed_o;
  logic [1:0]                 status_o;

  // Shadow copy of the rule store
  logic [padf_pkg::PortW-1:0] rule_port [padf_pkg::NumSets][padf_pkg::SetEntries];
  logic                       rule_live [padf_pkg::NumSets][padf_pkg::SetEntries];

  verdict_t pending_verdicts[$];
  int       mismatch_count = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;

  port_allow_deny_filter_top dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .opcode_i,
    .protocol_i,
    .list_select_i,
    .port_i,
    .out_valid_o,
    .out_ready_i,
    .allowed_o,
    .status_o
  );

  always #6 clk_i = ~clk_i;

  // Slot holding the port in a set, or -1
  function automatic int slot_of(input int set_idx, input logic [padf_pkg::PortW-1:0] port);
    int i;
    for (i = 0; i < padf_pkg::SetEntries; i++) begin
      if (rule_live[set_idx][i] && rule_port[set_idx][i] == port) return i;
    end
    return -1;
  endfunction

  function automatic bit set_is_empty(input int set_idx);
    int i;
    for (i = 0; i < padf_pkg::SetEntries; i++) begin
      if (rule_live[set_idx][i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Verdict for one request; applies any store update to the shadow copy
  function automatic verdict_t predict_verdict(input logic [1:0] op, input logic proto,
                                               input logic sel,
                                               input logic [padf_pkg::PortW-1:0] port);
    verdict_t v;
    int       allow_set;
    int       deny_set;
    int       target_set;
    int       hit;
    int       i;
    bit       allow_ok;
    bit       deny_ok;
    bit       placed;
    v.allowed  = 1'b0;
    v.status   = padf_pkg::StNoChange;
    allow_set  = 2 * int'(proto);
    deny_set   = allow_set + 1;
    target_set = allow_set + int'(sel);
    // Protocols beyond the store see two empty, read-only sets
    if (int'(proto) >= padf_pkg::NumProtocols) begin
      if (op == padf_pkg::OpCheck) begin
        v.allowed = 1'b1;
        v.status  = padf_pkg::StDone;
      end
      return v;
    end
    case (op)
      padf_pkg::OpCheck: begin
        v.status  = padf_pkg::StDone;
        allow_ok  = set_is_empty(allow_set) || slot_of(allow_set, port) >= 0;
        deny_ok   = set_is_empty(deny_set) || slot_of(deny_set, port) < 0;
        v.allowed = allow_ok && deny_ok;
      end
      padf_pkg::OpAdd: begin
        if (slot_of(target_set, port) < 0) begin
          v.status = padf_pkg::StFull;
          placed   = 1'b0;
          // lowest free slot wins
          for (i = 0; i < padf_pkg::SetEntries && !placed; i++) begin
            if (!rule_live[target_set][i]) begin
              rule_live[target_set][i] = 1'b1;
              rule_port[target_set][i] = port;
              v.status = padf_pkg::StDone;
              placed   = 1'b1;
            end
          end
        end
      end
      padf_pkg::OpDel: begin
        hit = slot_of(target_set, port);
        if (hit >= 0) begin
          rule_live[target_set][hit] = 1'b0;
          v.status = padf_pkg::StDone;
        end
      end
      default: begin
      end
    endcase
    return v;
  endfunction

  // Present one request beat, with an optional gap first, and log its verdict
  task automatic send_beat(input logic [1:0] op, input logic proto, input logic sel,
                           input logic [padf_pkg::PortW-1:0] port);
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    protocol_i    <= proto;
    list_select_i <= sel;
    port_i        <= port;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_verdicts.push_back(predict_verdict(op, proto, sel, port));
  endtask

  // Receiver back-pressure
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result beat check against the oldest pending verdict
  always @(posedge clk_i) begin
    verdict_t exp_v;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result beat allowed %0d status %0d",
                 $time, allowed_o, status_o);
        mismatch_count++;
      end else begin
        exp_v = pending_verdicts.pop_front();
        if (allowed_o !== exp_v.allowed) begin
          $display("%0t: allowed expected %0d actual %0d", $time, exp_v.allowed, allowed_o);
          mismatch_count++;
        end
        if (status_o !== exp_v.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_v.status, status_o);
          mismatch_count++;
        end
      end
    end
  end

  // Checks against an empty store, plus a delete with nothing to remove
  task automatic test_empty_store();
    send_beat(padf_pkg::OpCheck, 1'b0, 1'b0, 16'h0000);
    send_beat(padf_pkg::OpCheck, 1'b1, 1'b1, 16'hFFFF);
    send_beat(padf_pkg::OpDel, 1'b1, 1'b1, 16'hFFFF);
  endtask

  // Allow set: add, duplicate add, hit and miss, delete absent and present
  task automatic test_allow_rules();
    send_beat(padf_pkg::OpAdd, 1'b0, 1'b0, 16'h0000);
    send_beat(padf_pkg::OpAdd, 1'b0, 1'b0, 16'h0000);
    send_beat(padf_pkg::OpCheck, 1'b0, 1'b1, 16'h0000);
    send_beat(padf_pkg::OpCheck, 1'b0, 1'b0, 16'hFFFF);
    send_beat(padf_pkg::OpDel, 1'b0, 1'b0, 16'hFFFF);
    send_beat(padf_pkg::OpDel, 1'b0, 1'b0, 16'h0000);
  endtask

  // Deny set: a listed port is refused, others pass
  task automatic test_deny_rules();
    send_beat(padf_pkg::OpAdd, 1'b1, 1'b1, 16'hFFFF);
    send_beat(padf_pkg::OpCheck, 1'b1, 1'b0, 16'hFFFF);
    send_beat(padf_pkg::OpCheck, 1'b1, 1'b1, 16'h0000);
    send_beat(padf_pkg::OpDel, 1'b1, 1'b1, 16'hFFFF);
  endtask

  task automatic test_unused_opcode();
    send_beat(OpUnused, 1'b1, 1'b1, 16'hFFFF);
  endtask

  // Fill one set, then one add too many
  task automatic test_full_set();
    int i;
    for (i = 0; i <= padf_pkg::SetEntries; i++) begin
      send_beat(padf_pkg::OpAdd, 1'b0, 1'b1, 16'h8000 + 16'(i));
    end
  endtask

  // Mixed traffic: windows that alternately fill and drain a favoured set,
  // ports mostly from a small pool so that hits and full sets are common
  task automatic test_random_traffic(input int n_items, input int send_pct, input int recv_pct);
    int          k;
    int          roll;
    int          add_weight;
    int unsigned idx;
    logic [1:0]  op;
    logic        proto;
    logic        sel;
    logic        focus_proto;
    logic        focus_sel;
    logic [padf_pkg::PortW-1:0] port;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    focus_proto   = 1'b0;
    focus_sel     = 1'b0;
    for (k = 0; k < n_items; k++) begin
      if (k % 80 == 0) begin
        focus_proto = 1'($urandom_range(1));
        focus_sel   = 1'($urandom_range(1));
      end
      add_weight = ((k / 80) % 2 == 0) ? 55 : 15;
      roll = $urandom_range(99);
      if (roll < 4) op = OpUnused;
      else if (roll < 4 + add_weight) op = padf_pkg::OpAdd;
      else if (roll < 34 + add_weight) op = padf_pkg::OpCheck;
      else op = padf_pkg::OpDel;
      if ($urandom_range(99) < 70) begin
        proto = focus_proto;
        sel   = focus_sel;
      end else begin
        proto = 1'($urandom_range(1));
        sel   = 1'($urandom_range(1));
      end
      if ($urandom_range(99) < 85) begin
        idx  = $urandom_range(PoolSize - 1);
        port = (idx == PoolSize - 1) ? 16'hFFFF : 16'(idx * 3251);
      end else begin
        port = 16'($urandom_range(16'hFFFF));
      end
      send_beat(op, proto, sel, port);
    end
  endtask

  initial begin
    int s;
    int i;
    for (s = 0; s < padf_pkg::NumSets; s++) begin
      for (i = 0; i < padf_pkg::SetEntries; i++) begin
        rule_live[s][i] = 1'b0;
        rule_port[s][i] = '0;
      end
    end
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_store();
    test_allow_rules();
    test_deny_rules();
    test_unused_opcode();
    test_full_set();
    test_random_traffic(215, 21, 62);
    test_random_traffic(215, 62, 21);
    test_random_traffic(215, 0, 0);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (padf_pkg::SetEntries + 4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("%0t: timeout", $time);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
